// ----- hw/rtl/pva_pkg.sv -----
package pva_pkg;

   localparam int NUM_VOICES = 8;
   localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CNT_W = $clog2(NUM_VOICES + 1);

   // request commands
   localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
   localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
   localparam logic [1:0] CMD_ALL_OFF  = 2'd2;
   localparam logic [1:0] CMD_DONE     = 2'd3;

   // result actions
   localparam logic [2:0] ACT_NONE         = 3'd0;
   localparam logic [2:0] ACT_FREE_ASSIGN  = 3'd1;
   localparam logic [2:0] ACT_RETRIGGER    = 3'd2;
   localparam logic [2:0] ACT_STEAL_REL    = 3'd3;
   localparam logic [2:0] ACT_STEAL_HELD   = 3'd4;
   localparam logic [2:0] ACT_RELEASED     = 3'd5;
   localparam logic [2:0] ACT_FREED        = 3'd6;
   localparam logic [2:0] ACT_ALL_RELEASED = 3'd7;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] note;
      logic [6:0] velocity;
      logic [2:0] done_voice;
   } req_type;

   typedef struct packed {
      logic [2:0] voice_index;
      logic [2:0] action;
      logic [6:0] voice_note;
      logic [6:0] voice_velocity;
      logic [3:0] held_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic apply;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } ctl_stat_type;

   // clamp the held count to the 4-bit result field
   function automatic logic [3:0] sat_held(input logic [CNT_W-1:0] c);
      logic [CNT_W+3:0] w;
      w = (CNT_W + 4)'(c);
      if (w > (CNT_W + 4)'(15)) begin
         return 4'hF;
      end
      return w[3:0];
   endfunction

endpackage

// ----- hw/rtl/polyphonic_voice_allocator_core.sv -----
// Note_on and note_off with a nonzero note step through the load, scan, apply and result
// states before the rsp_valid strobe, the scan visiting every voice in turn; other commands
// leave the scan state without scanning. A new request is taken only once the block is idle
// again. The receiver cannot stall: each result shows for one cycle.
// Reset (synchronous, active high) frees every voice, clears held flags and the held count.
module polyphonic_voice_allocator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pva_pkg::req_type req_data,
   output logic             rsp_valid,
   output pva_pkg::rsp_type rsp_data
);
   import pva_pkg::*;

   ctl_cmd_type  ctl_cmd;
   ctl_stat_type ctl_stat;

   // Sequence each request: load, scan the voices, apply, then strobe the result.
   pva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (ctl_stat),
      .cmd       (ctl_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Hold the per-voice state, track first hits during the scan, and register the result.
   pva_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (ctl_cmd),
      .stat     (ctl_stat),
      .rsp_data (rsp_data)
   );

   // A result only closes out a request in flight.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a request in flight");

   // An accepted request makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // Exactly one result per request: the strobe lasts one cycle.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // The held count never exceeds the number of voices.
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_data.held_count) <= NUM_VOICES))
      else $error("held count above voice count");

   // A result with no action names voice 0 and carries no note.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.action == ACT_NONE)) |->
         ((rsp_data.voice_index == 3'd0) && (rsp_data.voice_note == 7'd0)))
      else $error("no-op result carries a voice");

endmodule

// ----- hw/rtl/pva_ctrl.sv -----
module pva_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  pva_pkg::ctl_stat_type stat,
   output pva_pkg::ctl_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import pva_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/pva_datapath.sv -----
module pva_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  pva_pkg::req_type      req_data,
   input  pva_pkg::ctl_cmd_type  cmd,
   output pva_pkg::ctl_stat_type stat,
   output pva_pkg::rsp_type      rsp_data
);
   import pva_pkg::*;

   req_type              req_ff;
   logic [VIDX_W-1:0]    ptr_ff, ptr_in;
   logic [NUM_VOICES-1:0] busy_ff, busy_in;
   logic [NUM_VOICES-1:0] held_ff, held_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [6:0]           note_ff [NUM_VOICES];
   logic [6:0]           vel_ff  [NUM_VOICES];
   rsp_type              rsp_ff, rsp_in;

   // first-hit trackers of the scan
   logic                 hmatch_ff, hmatch_in;
   logic [VIDX_W-1:0]    hmatch_idx_ff, hmatch_idx_in;
   logic                 bmatch_ff, bmatch_in;
   logic [VIDX_W-1:0]    bmatch_idx_ff, bmatch_idx_in;
   logic                 free_ff, free_in;
   logic [VIDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                 rel_ff, rel_in;
   logic [VIDX_W-1:0]    rel_idx_ff, rel_idx_in;

   logic                 scan_needed;
   logic                 entry_match;
   logic [VIDX_W+3:0]    dv_wide;
   logic                 dv_ok;
   logic [VIDX_W-1:0]    sel_idx;
   logic [2:0]           sel_act;
   logic                 sel_hit;
   logic                 wr_en;
   logic [6:0]           wr_note;
   logic [6:0]           wr_vel;
   logic [VIDX_W+3:0]    idx_wide;

   assign scan_needed = ((req_ff.command == CMD_NOTE_ON) || (req_ff.command == CMD_NOTE_OFF))
                        && (req_ff.note != 7'd0);
   assign stat.scan_done = !scan_needed || (ptr_ff == VIDX_W'(NUM_VOICES - 1));
   assign entry_match = busy_ff[ptr_ff] && (note_ff[ptr_ff] == req_ff.note);
   assign dv_wide = (VIDX_W + 4)'(req_ff.done_voice);
   assign dv_ok = dv_wide < (VIDX_W + 4)'(NUM_VOICES);

   // scan one voice per cycle
   always_comb begin
      ptr_in        = ptr_ff;
      hmatch_in     = hmatch_ff;
      hmatch_idx_in = hmatch_idx_ff;
      bmatch_in     = bmatch_ff;
      bmatch_idx_in = bmatch_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      rel_in        = rel_ff;
      rel_idx_in    = rel_idx_ff;
      if (cmd.load) begin
         ptr_in    = '0;
         hmatch_in = 1'b0;
         bmatch_in = 1'b0;
         free_in   = 1'b0;
         rel_in    = 1'b0;
      end else if (cmd.scan) begin
         ptr_in = ptr_ff + VIDX_W'(1);
         if (!hmatch_ff && entry_match && held_ff[ptr_ff]) begin
            hmatch_in     = 1'b1;
            hmatch_idx_in = ptr_ff;
         end
         if (!bmatch_ff && entry_match) begin
            bmatch_in     = 1'b1;
            bmatch_idx_in = ptr_ff;
         end
         if (!free_ff && !busy_ff[ptr_ff]) begin
            free_in     = 1'b1;
            free_idx_in = ptr_ff;
         end
         if (!rel_ff && !held_ff[ptr_ff]) begin
            rel_in     = 1'b1;
            rel_idx_in = ptr_ff;
         end
      end
   end

   // pick the affected voice from the scan results
   always_comb begin
      sel_idx = '0;
      sel_act = ACT_NONE;
      sel_hit = 1'b0;
      case (req_ff.command)
         CMD_NOTE_ON: begin
            if (req_ff.note != 7'd0) begin
               sel_hit = 1'b1;
               if (hmatch_ff) begin
                  sel_idx = hmatch_idx_ff;
                  sel_act = ACT_RETRIGGER;
               end else if (bmatch_ff) begin
                  sel_idx = bmatch_idx_ff;
                  sel_act = ACT_RETRIGGER;
               end else if (free_ff) begin
                  sel_idx = free_idx_ff;
                  sel_act = ACT_FREE_ASSIGN;
               end else if (rel_ff) begin
                  sel_idx = rel_idx_ff;
                  sel_act = ACT_STEAL_REL;
               end else begin
                  sel_act = ACT_STEAL_HELD;
               end
            end
         end
         CMD_NOTE_OFF: begin
            if (req_ff.note != 7'd0) begin
               if (hmatch_ff) begin
                  sel_hit = 1'b1;
                  sel_idx = hmatch_idx_ff;
                  sel_act = ACT_RELEASED;
               end else if (bmatch_ff) begin
                  sel_hit = 1'b1;
                  sel_idx = bmatch_idx_ff;
                  sel_act = ACT_RELEASED;
               end
            end
         end
         CMD_ALL_OFF: begin
            sel_act = ACT_ALL_RELEASED;
         end
         CMD_DONE: begin
            sel_idx = dv_wide[VIDX_W-1:0];
            if (dv_ok && busy_ff[sel_idx]) begin
               sel_hit = 1'b1;
               sel_act = ACT_FREED;
            end
         end
         default: begin
            sel_act = ACT_NONE;
         end
      endcase
   end

   // apply the update and build the result
   always_comb begin
      busy_in  = busy_ff;
      held_in  = held_ff;
      cnt_in   = cnt_ff;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      wr_note  = req_ff.note;
      wr_vel   = req_ff.velocity;
      idx_wide = (VIDX_W + 4)'(sel_idx);
      if (cmd.apply) begin
         rsp_in.voice_index    = sel_hit ? idx_wide[2:0] : 3'd0;
         rsp_in.action         = sel_act;
         rsp_in.voice_note     = 7'd0;
         rsp_in.voice_velocity = 7'd0;
         case (sel_act)
            ACT_FREE_ASSIGN, ACT_RETRIGGER, ACT_STEAL_REL, ACT_STEAL_HELD: begin
               busy_in[sel_idx] = 1'b1;
               held_in[sel_idx] = 1'b1;
               if (!held_ff[sel_idx]) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               wr_en = 1'b1;
               rsp_in.voice_note     = req_ff.note;
               rsp_in.voice_velocity = req_ff.velocity;
            end
            ACT_RELEASED: begin
               held_in[sel_idx] = 1'b0;
               if (held_ff[sel_idx]) begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
               rsp_in.voice_note     = req_ff.note;
               rsp_in.voice_velocity = vel_ff[sel_idx];
            end
            ACT_ALL_RELEASED: begin
               held_in = '0;
               cnt_in  = '0;
            end
            ACT_FREED: begin
               busy_in[sel_idx] = 1'b0;
               held_in[sel_idx] = 1'b0;
               if (held_ff[sel_idx]) begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
               wr_en   = 1'b1;
               wr_note = 7'd0;
               wr_vel  = 7'd0;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
         rsp_in.held_count = sat_held(cnt_in);
      end
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         held_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         held_ff <= held_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      ptr_ff        <= ptr_in;
      hmatch_ff     <= hmatch_in;
      hmatch_idx_ff <= hmatch_idx_in;
      bmatch_ff     <= bmatch_in;
      bmatch_idx_ff <= bmatch_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      rel_ff        <= rel_in;
      rel_idx_ff    <= rel_idx_in;
      rsp_ff        <= rsp_in;
      if (wr_en) begin
         note_ff[sel_idx] <= wr_note;
         vel_ff[sel_idx]  <= wr_vel;
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import pva_pkg::*;

   localparam int NV = NUM_VOICES;

   // Generous ceiling: the ~1650 requests of the run fit in well under a fifth of it.
   localparam int RUN_LIMIT_NS = 5_000_000;

   // Random request phases and requests per phase; each phase's idle rate, in percent, is in idle_pct.
   localparam int PHASE_COUNT = 3;
   localparam int PHASE_REQUESTS = 545;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow copy of the voice bank, updated once per accepted request.
   logic       voice_busy [NV];
   logic       voice_held [NV];
   logic [6:0] voice_note [NV];
   logic [6:0] voice_vel  [NV];

   rsp_type      expected_rsp [$];
   stim_row_type directed_rows [$];
   rsp_type      want_rsp;

   int fail_count = 0;
   int cmd_seen [4];
   int act_seen [8];

   polyphonic_voice_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Return the voice sounding this note: a held one first, then any busy one; -1 if none.
   function automatic int find_voice_by_note(input logic [6:0] n);
      for (int v = 0; v < NV; v++) begin
         if (voice_held[v] && voice_busy[v] && voice_note[v] == n) begin
            return v;
         end
      end
      for (int v = 0; v < NV; v++) begin
         if (voice_busy[v] && voice_note[v] == n) begin
            return v;
         end
      end
      return -1;
   endfunction

   // Apply one request to the shadow voice bank and return the result it must produce.
   function automatic rsp_type predict_voice_event(input req_type r);
      rsp_type o;
      int      slot;
      int      held;
      logic [2:0] act;
      slot = -1;
      act  = ACT_NONE;
      held = 0;
      case (r.command)
         CMD_NOTE_ON: begin
            if (r.note != 7'd0) begin
               slot = find_voice_by_note(r.note);
               if (slot >= 0) begin
                  act = ACT_RETRIGGER;
               end else begin
                  // prefer a free voice, then a releasing one, else steal voice 0
                  for (int v = 0; v < NV && slot < 0; v++) begin
                     if (!voice_busy[v]) begin
                        slot = v;
                        act  = ACT_FREE_ASSIGN;
                     end
                  end
                  for (int v = 0; v < NV && slot < 0; v++) begin
                     if (!voice_held[v]) begin
                        slot = v;
                        act  = ACT_STEAL_REL;
                     end
                  end
                  if (slot < 0) begin
                     slot = 0;
                     act  = ACT_STEAL_HELD;
                  end
               end
               voice_busy[slot] = 1'b1;
               voice_held[slot] = 1'b1;
               voice_note[slot] = r.note;
               voice_vel[slot]  = r.velocity;
            end
         end
         CMD_NOTE_OFF: begin
            if (r.note != 7'd0) begin
               slot = find_voice_by_note(r.note);
               if (slot >= 0) begin
                  voice_held[slot] = 1'b0;
                  act = ACT_RELEASED;
               end
            end
         end
         CMD_ALL_OFF: begin
            for (int v = 0; v < NV; v++) begin
               voice_held[v] = 1'b0;
            end
            act = ACT_ALL_RELEASED;
         end
         default: begin
            if (int'(r.done_voice) < NV && voice_busy[r.done_voice]) begin
               slot = int'(r.done_voice);
               voice_busy[slot] = 1'b0;
               voice_held[slot] = 1'b0;
               voice_note[slot] = 7'd0;
               voice_vel[slot]  = 7'd0;
               act = ACT_FREED;
            end
         end
      endcase
      o = '0;
      if (slot >= 0) begin
         o.voice_index    = 3'(slot);
         o.voice_note     = voice_note[slot];
         o.voice_velocity = voice_vel[slot];
      end
      o.action = act;
      for (int v = 0; v < NV; v++) begin
         if (voice_held[v]) begin
            held++;
         end
      end
      o.held_count = (held > 15) ? 4'hF : 4'(held);
      return o;
   endfunction

   function automatic rsp_type mk_rsp(input int idx, input logic [2:0] act, input int n,
                                      input int vel, input int held);
      rsp_type o;
      o.voice_index    = 3'(idx);
      o.action         = act;
      o.voice_note     = 7'(n);
      o.voice_velocity = 7'(vel);
      o.held_count     = 4'(held);
      return o;
   endfunction

   task automatic add_row(input logic [1:0] cmd, input int n, input int vel, input int dv,
                          input bit typed = 1'b0, input rsp_type want = '0);
      stim_row_type row;
      row.req.command    = cmd;
      row.req.note       = 7'(n);
      row.req.velocity   = 7'(vel);
      row.req.done_voice = 3'(dv);
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   // Build a mostly well-formed request: notes from a narrow band so voices collide and get
   // stolen, note-offs and done events aimed at live voices, plus a little noise.
   function automatic req_type next_random_request();
      req_type r;
      int      pick;
      int      held_list [$];
      int      busy_list [$];
      r.command    = 2'($urandom_range(3));
      r.note       = 7'($urandom_range(127));
      r.velocity   = 7'($urandom_range(127));
      r.done_voice = 3'($urandom_range(7));
      for (int v = 0; v < NV; v++) begin
         if (voice_held[v]) begin
            held_list.push_back(v);
         end
         if (voice_busy[v]) begin
            busy_list.push_back(v);
         end
      end
      pick = $urandom_range(99);
      if (pick < 42) begin
         r.command = CMD_NOTE_ON;
         if ($urandom_range(3) != 0) begin
            r.note = 7'($urandom_range(67, 56));
         end
      end else if (pick < 72) begin
         r.command = CMD_NOTE_OFF;
         if (held_list.size() != 0 && $urandom_range(4) != 0) begin
            r.note = voice_note[held_list[$urandom_range(held_list.size() - 1)]];
         end
      end else if (pick < 94) begin
         r.command = CMD_DONE;
         if (busy_list.size() != 0 && $urandom_range(3) != 0) begin
            r.done_voice = 3'(busy_list[$urandom_range(busy_list.size() - 1)]);
         end
      end else if (pick < 97) begin
         r.command = CMD_ALL_OFF;
      end else begin
         // note zero on any command: ignored by note events, harmless elsewhere
         r.note = 7'd0;
      end
      return r;
   endfunction

   // Present one request, idling each cycle with the given odds first, and hold it until
   // the core takes it. Call right after a rising edge; returns at the accepting edge.
   task automatic send_request(input req_type r, input int idle_pct,
                               input bit typed = 1'b0, input rsp_type want = '0);
      rsp_type pred;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pred = predict_voice_event(r);
      expected_rsp.push_back(typed ? want : pred);
      cmd_seen[r.command]++;
   endtask

   // Drop start and hold off until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   // Check each result strobe against the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         act_seen[rsp_data.action]++;
         if (expected_rsp.size() == 0) begin
            $error("result with no request outstanding: %p", rsp_data);
            fail_count++;
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (rsp_data.voice_index !== want_rsp.voice_index) begin
               $error("voice_index: expected %0d, got %0d",
                      want_rsp.voice_index, rsp_data.voice_index);
               fail_count++;
            end
            if (rsp_data.action !== want_rsp.action) begin
               $error("action: expected %0d, got %0d", want_rsp.action, rsp_data.action);
               fail_count++;
            end
            if (rsp_data.voice_note !== want_rsp.voice_note) begin
               $error("voice_note: expected %0d, got %0d",
                      want_rsp.voice_note, rsp_data.voice_note);
               fail_count++;
            end
            if (rsp_data.voice_velocity !== want_rsp.voice_velocity) begin
               $error("voice_velocity: expected %0d, got %0d",
                      want_rsp.voice_velocity, rsp_data.voice_velocity);
               fail_count++;
            end
            if (rsp_data.held_count !== want_rsp.held_count) begin
               $error("held_count: expected %0d, got %0d",
                      want_rsp.held_count, rsp_data.held_count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int idle_pct [PHASE_COUNT];
      rsp_type none;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      for (int v = 0; v < NV; v++) begin
         voice_busy[v] = 1'b0;
         voice_held[v] = 1'b0;
         voice_note[v] = 7'd0;
         voice_vel[v]  = 7'd0;
      end
      idle_pct[0] = 37;
      idle_pct[1] = 76;
      idle_pct[2] = 0;
      none = mk_rsp(0, ACT_NONE, 0, 0, 0);

      // Directed table. Rows with an expectation typed in are plain to read off; the rest
      // go through the predictor.
      add_row(CMD_NOTE_OFF, 60, 0, 0, 1'b1, none);            // nothing sounding yet
      add_row(CMD_DONE, 0, 0, 7, 1'b1, none);                 // done on an idle voice
      add_row(CMD_NOTE_ON, 0, 127, 0, 1'b1, none);            // note zero is ignored
      add_row(CMD_NOTE_OFF, 0, 127, 0, 1'b1, none);
      add_row(CMD_NOTE_ON, 127, 127, 0, 1'b1, mk_rsp(0, ACT_FREE_ASSIGN, 127, 127, 1));
      add_row(CMD_NOTE_ON, 1, 0, 0, 1'b1, mk_rsp(1, ACT_FREE_ASSIGN, 1, 0, 2));
      add_row(CMD_NOTE_ON, 127, 5, 0);                        // retrigger held voice
      for (int n = 10; n < 16; n++) begin
         add_row(CMD_NOTE_ON, n, 64 + n, 7);                  // fill the bank
      end
      add_row(CMD_NOTE_ON, 20, 100, 0);                       // all held: steal voice 0
      add_row(CMD_NOTE_OFF, 1, 0, 0);                         // release
      add_row(CMD_NOTE_OFF, 1, 0, 0);                         // release a releasing voice
      add_row(CMD_NOTE_ON, 30, 33, 0);                        // steal the releasing voice
      add_row(CMD_ALL_OFF, 127, 127, 7, 1'b1, mk_rsp(0, ACT_ALL_RELEASED, 0, 0, 0));
      add_row(CMD_NOTE_ON, 10, 1, 0);                         // retrigger a released voice
      add_row(CMD_DONE, 0, 0, 3);                             // free a busy voice
      add_row(CMD_DONE, 0, 0, 3);                             // already free
      add_row(CMD_NOTE_OFF, 99, 0, 0);                        // no voice matches
      add_row(CMD_DONE, 0, 0, 2);                             // free a held voice
      add_row(CMD_NOTE_ON, 64, 127, 0);                       // lowest free voice wins
      add_row(CMD_ALL_OFF, 0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, idle_pct[0], directed_rows[i].typed,
                      directed_rows[i].want);
      end
      drain_results();

      // Random phases: sender idles sometimes, then often, then never.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            // now and then, let the pipe empty completely before the next request
            if ($urandom_range(49) == 0) begin
               drain_results();
            end
            send_request(next_random_request(), idle_pct[p]);
         end
         drain_results();
      end

      // Let any stray strobe show up before calling the run.
      repeat (4 * NV) @(posedge clock);

      $display("Covered %0d requests: %0d note-on, %0d note-off, %0d all-off, %0d done.",
               cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
               cmd_seen[CMD_NOTE_ON], cmd_seen[CMD_NOTE_OFF], cmd_seen[CMD_ALL_OFF],
               cmd_seen[CMD_DONE]);
      $display("Saw %0d free assigns, %0d retriggers, %0d releasing steals, %0d held steals.",
               act_seen[ACT_FREE_ASSIGN], act_seen[ACT_RETRIGGER], act_seen[ACT_STEAL_REL],
               act_seen[ACT_STEAL_HELD]);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("Timed out with %0d results outstanding", expected_rsp.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
